>>> rtl/abs_variant_escape_time_fractal_macros.svh
// Assertion macros shared by the checker of the escape-time fractal block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ABS_VARIANT_ESCAPE_TIME_FRACTAL_MACROS_SVH
`define ABS_VARIANT_ESCAPE_TIME_FRACTAL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AVETF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escape-time fractal check failed");

// Next-cycle implication, disabled during reset.
`define AVETF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escape-time fractal check failed");

// Property that must hold on the cycle after an edge at which reset is applied.
`define AVETF_ASSERT_IN_RESET(label, cons) \
  label: assert property (@(posedge clk_i) !rst_ni |=> (cons)) \
    else $error("escape-time fractal reset check failed");

`endif

>>> rtl/avetf_pkg.sv
// Types, constants and helper functions of the escape-time fractal block.
// Used by every RTL file of the block; depends on nothing.
`timescale 1ns / 1ps

package avetf_pkg;

  localparam int unsigned PixW    = 10;
  localparam int unsigned StepW   = 31;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned IterW   = 16;
  localparam int unsigned IdxW    = 20;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned DivDividendW = IterW + ColorW;
  localparam int unsigned DivBitsPerCycle = 2;
  localparam int unsigned DivSteps = DivDividendW / DivBitsPerCycle;

  localparam int unsigned QDepth = 2;

  localparam logic [31:0] MagicThird = 32'haaaa_aaab;
  localparam logic [63:0] EscapeLimit = 64'd4 << 48;

  localparam logic signed [63:0] SatHi = 64'sd2147483647;
  localparam logic signed [63:0] SatLo = -64'sd2147483648;

  localparam logic [StepW-1:0]  RstPixelStep  = 31'd167772;
  localparam logic [CoordW-1:0] RstRealOffset = 32'hfe00_0000;
  localparam logic [CoordW-1:0] RstImagOffset = 32'hfe00_0000;
  localparam logic [IterW-1:0]  RstMaxIter    = 16'd100;
  localparam logic [ColorW-1:0] RstInsideColor = 24'hff0000;
  localparam logic [ColorW-1:0] RstScaleColor  = 24'h00ff00;

  typedef enum logic [CfgAddrW-1:0] {
    CfgPixelStep   = 3'd0,
    CfgRealOffset  = 3'd1,
    CfgImagOffset  = 3'd2,
    CfgMaxIter     = 3'd3,
    CfgInsideColor = 3'd4,
    CfgScaleColor  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [StepW-1:0]         pixel_step;
    logic signed [CoordW-1:0] real_offset;
    logic signed [CoordW-1:0] imag_offset;
    logic [IterW-1:0]         max_iter;
    logic [ColorW-1:0]        inside_color;
    logic [ColorW-1:0]        scale_color;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [IterW-1:0]  iterations;
    logic              inside_res;
    logic [IdxW-1:0]   pixel_index;
    logic [ColorW-1:0] pixel_color;
  } pix_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] crd;
    logic signed [CoordW-1:0] ci;
    logic [IdxW-1:0]          idx;
  } job_t;

  typedef struct packed {
    logic                    start;
    logic [DivDividendW-1:0] dividend;
    logic [IterW-1:0]        divisor;
  } div_req_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [63:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[CoordW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/avetf_front.sv
// Front end: accepts pixel beats and forms c and the scaled real part c*2/3.
// Three register stages; depends on avetf_pkg.
`timescale 1ns / 1ps

module avetf_front import avetf_pkg::*; #(
  parameter int unsigned IMG_WIDTH = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  pix_in_t in_data_i,
  output logic    job_valid_o,
  input  logic    job_ready_i,
  output job_t    job_o
);

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic [PixW+StepW-1:0] prx_q, pry_q, prx_d, pry_d;
  logic [IdxW-1:0] idx1_q, idx2_q, idx3_q, idx1_d;

  logic signed [63:0] sum_r, sum_i;
  logic signed [CoordW-1:0] cr, ci;
  logic [CoordW-1:0] abs_d, abs2_q, abs3_q;
  logic neg2_q, neg3_q;
  logic signed [CoordW-1:0] ci2_q, ci3_q;

  logic [63:0] prod;
  logic [CoordW-2:0] k_q;

  logic [CoordW:0] three_k, rem;
  logic [CoordW-1:0] mag;

  assign adv = !v3_q || job_ready_i;
  assign in_ready_o = adv;

  assign prx_d = {{StepW{1'b0}}, in_data_i.pixel_x} * {{PixW{1'b0}}, cfg_i.pixel_step};
  assign pry_d = {{StepW{1'b0}}, in_data_i.pixel_y} * {{PixW{1'b0}}, cfg_i.pixel_step};
  assign idx1_d = {{(IdxW-PixW){1'b0}}, in_data_i.pixel_x}
                + {{(IdxW-PixW){1'b0}}, in_data_i.pixel_y} * IdxW'(IMG_WIDTH);

  assign sum_r = {{(64-PixW-StepW){1'b0}}, prx_q}
               + {{(64-CoordW){cfg_i.real_offset[CoordW-1]}}, cfg_i.real_offset};
  assign sum_i = {{(64-PixW-StepW){1'b0}}, pry_q}
               + {{(64-CoordW){cfg_i.imag_offset[CoordW-1]}}, cfg_i.imag_offset};
  assign cr = sat32(sum_r);
  assign ci = sat32(sum_i);
  assign abs_d = cr[CoordW-1] ? (~cr + 32'd1) : cr;

  assign prod = {32'b0, abs2_q} * {32'b0, MagicThird};

  assign three_k = {1'b0, k_q, 1'b0} + {2'b00, k_q};
  assign rem = {1'b0, abs3_q} - three_k;
  assign mag = {k_q, 1'b0} + {{(CoordW-1){1'b0}}, (rem[1:0] == 2'd2)};

  assign job_valid_o = v3_q;
  assign job_o.crd = neg3_q ? (~mag + 32'd1) : mag;
  assign job_o.ci = ci3_q;
  assign job_o.idx = idx3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prx_q  <= prx_d;
      pry_q  <= pry_d;
      idx1_q <= idx1_d;
      abs2_q <= abs_d;
      neg2_q <= cr[CoordW-1];
      ci2_q  <= ci;
      idx2_q <= idx1_q;
      k_q    <= prod[63:33];
      abs3_q <= abs2_q;
      neg3_q <= neg2_q;
      ci3_q  <= ci2_q;
      idx3_q <= idx2_q;
    end
  end

endmodule

>>> rtl/avetf_fifo.sv
// Short job queue between the front end and the iteration engine.
// Depth comes from avetf_pkg.
`timescale 1ns / 1ps

module avetf_fifo import avetf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t entries_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/avetf_div.sv
// Radix-4 restoring divider for the color scaling of escaping points.
// Depends on avetf_pkg.
`timescale 1ns / 1ps

module avetf_div import avetf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [ColorW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivDividendW-1:0] sh_q, sh_d;
  logic [IterW-1:0] rem_q, rem_d, dsr_q;

  always_comb begin
    logic [IterW:0] t;
    logic [IterW-1:0] r;
    logic [DivDividendW-1:0] s;
    r = rem_q;
    s = sh_q;
    for (int j = 0; j < DivBitsPerCycle; j++) begin
      t = {r, s[DivDividendW-1]};
      s = {s[DivDividendW-2:0], 1'b0};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
        s[0] = 1'b1;
      end
      r = t[IterW-1:0];
    end
    rem_d = r;
    sh_d = s;
  end

  assign done_o = done_q;
  assign quot_o = sh_q[ColorW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

endmodule

>>> rtl/avetf_iter.sv
// Iteration engine: runs the absolute-value escape recurrence for one job,
// picks the color and holds the result beat. Depends on avetf_pkg, avetf_div.
`timescale 1ns / 1ps

module avetf_iter import avetf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     job_valid_i,
  output logic     job_pop_o,
  input  job_t     job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StChk  = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] zr_q, zr_d, zi_q, zi_d, crd_q, crd_d, ci_q, ci_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IterW-1:0] it_q, it_d;
  logic [63:0] r2_q, r2_d, i2_q, i2_d;
  logic signed [63:0] x_q, x_d;
  logic inside_q, inside_d;
  logic [ColorW-1:0] color_q, color_d;
  logic out_valid_q, load_out;
  pix_out_t out_q;

  logic signed [63:0] sq_r, sq_i, cross_p;
  logic [63:0] diff;
  logic signed [63:0] zr_sum, zi_sum, cross_ext;
  logic escape, limit;

  div_req_t div_req;
  logic div_done;
  logic [ColorW-1:0] div_quot;

  avetf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign sq_r = zr_q * zr_q;
  assign sq_i = zi_q * zi_q;
  assign cross_p = zi_q * zr_q;

  assign escape = (r2_q + i2_q) >= EscapeLimit;
  assign limit = (it_q >= cfg_i.max_iter);
  assign diff = (r2_q >= i2_q) ? (r2_q - i2_q) : (i2_q - r2_q);
  assign zr_sum = {24'b0, diff[63:24]} + {{(64-CoordW){crd_q[CoordW-1]}}, crd_q};
  assign cross_ext = {{24{x_q[63]}}, x_q[63:24]};
  assign zi_sum = cross_ext + (cross_ext <<< 1) + {{(64-CoordW){ci_q[CoordW-1]}}, ci_q};

  always_comb begin
    state_d  = state_q;
    zr_d     = zr_q;
    zi_d     = zi_q;
    crd_d    = crd_q;
    ci_d     = ci_q;
    idx_d    = idx_q;
    it_d     = it_q;
    r2_d     = r2_q;
    i2_d     = i2_q;
    x_d      = x_q;
    inside_d = inside_q;
    color_d  = color_q;
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {{ColorW{1'b0}}, it_q} * {{IterW{1'b0}}, cfg_i.scale_color};
    div_req.divisor  = cfg_i.max_iter;
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          crd_d = job_i.crd;
          ci_d  = job_i.ci;
          idx_d = job_i.idx;
          zr_d  = '0;
          zi_d  = '0;
          it_d  = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        r2_d = sq_r;
        i2_d = sq_i;
        x_d  = cross_p;
        state_d = StChk;
      end
      StChk: begin
        if (escape || limit) begin
          inside_d = (it_q == cfg_i.max_iter);
          if (it_q == cfg_i.max_iter) begin
            color_d = cfg_i.inside_color;
            state_d = StDone;
          end else begin
            div_req.start = 1'b1;
            state_d = StDiv;
          end
        end else begin
          zr_d = sat32(zr_sum);
          zi_d = sat32(zi_sum);
          it_d = it_q + 16'd1;
          state_d = StMul;
        end
      end
      StDiv: begin
        if (div_done) begin
          color_d = div_quot;
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q     <= zr_d;
    zi_q     <= zi_d;
    crd_q    <= crd_d;
    ci_q     <= ci_d;
    idx_q    <= idx_d;
    it_q     <= it_d;
    r2_q     <= r2_d;
    i2_q     <= i2_d;
    x_q      <= x_d;
    inside_q <= inside_d;
    color_q  <= color_d;
    if (load_out) begin
      out_q.iterations  <= it_q;
      out_q.inside_res  <= inside_q;
      out_q.pixel_index <= idx_q;
      out_q.pixel_color <= color_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/abs_variant_escape_time_fractal.sv
// Escape-time fractal, absolute-value variant. A pixel beat passes the front register stages
// and the job queue, then the iteration engine runs its multiply/update loop (StMul, StChk)
// for N iterations, plus the color division when the point escapes. The engine holds one
// pixel at a time and pops the next job only once it has handed on the last result beat.
// Reset is asynchronous, active low: it restores the register defaults and empties the
// pipeline and queue; no memory needs clearing.
`timescale 1ns / 1ps

module abs_variant_escape_time_fractal import avetf_pkg::*; #(
  parameter int unsigned IMG_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o
);

  cfg_t cfg_q, cfg_d;

  logic job_valid, job_ready, q_valid, q_pop;
  job_t job, q_job;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgPixelStep:   cfg_d.pixel_step   = cfg_wdata_i[StepW-1:0];
        CfgRealOffset:  cfg_d.real_offset  = cfg_wdata_i;
        CfgImagOffset:  cfg_d.imag_offset  = cfg_wdata_i;
        CfgMaxIter:     cfg_d.max_iter     = cfg_wdata_i[IterW-1:0];
        CfgInsideColor: cfg_d.inside_color = cfg_wdata_i[ColorW-1:0];
        CfgScaleColor:  cfg_d.scale_color  = cfg_wdata_i[ColorW-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_step   <= RstPixelStep;
      cfg_q.real_offset  <= RstRealOffset;
      cfg_q.imag_offset  <= RstImagOffset;
      cfg_q.max_iter     <= RstMaxIter;
      cfg_q.inside_color <= RstInsideColor;
      cfg_q.scale_color  <= RstScaleColor;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  avetf_front #(
    .IMG_WIDTH (IMG_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  avetf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_job)
  );

  avetf_iter u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/avetf_checker.sv
// Port-level checker for the escape-time fractal block, bound to the top level.
// Depends on avetf_pkg and abs_variant_escape_time_fractal_macros.svh.
`timescale 1ns / 1ps
`include "abs_variant_escape_time_fractal_macros.svh"

module avetf_checker import avetf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pix_out_t out_data_o
);

  // A stalled result beat must stay put.
  `AVETF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // An escaping point always ran at least one iteration.
  `AVETF_ASSERT_NOW(a_escape_iter, out_valid_o && !out_data_o.inside_res, out_data_o.iterations != 16'd0)

  `AVETF_ASSERT_IN_RESET(a_reset_quiet, !out_valid_o)

endmodule

bind abs_variant_escape_time_fractal avetf_checker u_checker (.*);
